>>> rtl/core/fbvs_pkg.sv
package fbvs_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int POS_W       = IDX_W + 1;
    localparam int TAG_W       = 16;
    localparam int ID_W        = 32;
    localparam int VICTIM_W    = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HAS_FOCUS     = 2'd0,
        CFG_FOCUS_ID      = 2'd1,
        CFG_FOCUS_TABLE   = 2'd2,
        CFG_FOCUS_GRAPHIC = 2'd3
    } cfg_index_t;

    // one buffer entry after tag match and distance
    typedef struct packed {
        logic            free;
        logic            focus_match;
        logic [ID_W-1:0] distance;
        logic            last;
    } entry_t;

    // focus settings seen by the entry stage
    typedef struct packed {
        logic [ID_W-1:0]  focus_id;
        logic [TAG_W-1:0] table_tag;
        logic [TAG_W-1:0] graphic_tag;
    } focus_t;

    function automatic logic [VICTIM_W-1:0] to_victim(input logic [IDX_W-1:0] idx);
        logic [IDX_W+VICTIM_W-1:0] wide;
        wide = {{VICTIM_W{1'b0}}, idx};
        return wide[VICTIM_W-1:0];
    endfunction

endpackage

>>> rtl/core/fbvs_entry_stage.sv
module fbvs_entry_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         in_use,
    input  logic [fbvs_pkg::TAG_W-1:0]   owner_tag,
    input  logic [fbvs_pkg::ID_W-1:0]    start_id,
    input  logic                         last_entry,
    input  fbvs_pkg::focus_t             focus,
    input  logic                         advance,
    output logic                         entry_valid,
    output fbvs_pkg::entry_t             entry
);
    import fbvs_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic   load;
    entry_t entry_reg;
    entry_t entry_next;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        entry_next.free        = !in_use;
        entry_next.focus_match = (owner_tag == focus.table_tag) ||
                                 (owner_tag == focus.graphic_tag);
        entry_next.distance    = (start_id > focus.focus_id) ? (start_id - focus.focus_id)
                                                             : (focus.focus_id - start_id);
        entry_next.last        = last_entry;
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            entry_reg <= entry_next;
    end

    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

endmodule

>>> rtl/core/fbvs_tracker.sv
module fbvs_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           entry_valid,
    input  fbvs_pkg::entry_t               entry,
    input  logic                           has_focus,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [fbvs_pkg::VICTIM_W-1:0]  victim_index
);
    import fbvs_pkg::*;

    logic [POS_W-1:0]    scan_pos_reg,   scan_pos_next;
    logic [IDX_W-1:0]    first_free_reg, first_free_next;
    logic                have_free_reg,  have_free_next;
    logic [IDX_W-1:0]    best_idx_reg,   best_idx_next;
    logic                have_match_reg, have_match_next;
    logic [ID_W-1:0]     best_dist_reg,  best_dist_next;
    logic                out_valid_reg,  out_valid_next;
    logic                found_reg,      found_next;
    logic [VICTIM_W-1:0] victim_reg,     victim_next;

    logic             take;
    logic             in_range;
    logic [IDX_W-1:0] cur_idx;
    logic             upd_have_free;
    logic [IDX_W-1:0] upd_first_free;
    logic             upd_have_match;
    logic [IDX_W-1:0] upd_best_idx;
    logic [ID_W-1:0]  upd_best_dist;

    // a scan end needs the output register; other entries always move on
    assign advance  = !entry.last || !out_valid_reg || !out_stall;
    assign take     = entry_valid && advance;
    assign in_range = scan_pos_reg < POS_W'(MAX_ENTRIES);
    assign cur_idx  = scan_pos_reg[IDX_W-1:0];

    always_comb
    begin
        upd_have_free  = have_free_reg;
        upd_first_free = first_free_reg;
        upd_have_match = have_match_reg;
        upd_best_idx   = best_idx_reg;
        upd_best_dist  = best_dist_reg;
        if (in_range && entry.free)
        begin
            if (!have_free_reg)
            begin
                upd_have_free  = 1'b1;
                upd_first_free = cur_idx;
            end
            // strict compare keeps the earlier entry on a tie
            if (entry.focus_match && (!have_match_reg || entry.distance > best_dist_reg))
            begin
                upd_have_match = 1'b1;
                upd_best_idx   = cur_idx;
                upd_best_dist  = entry.distance;
            end
        end
    end

    always_comb
    begin
        scan_pos_next   = scan_pos_reg;
        first_free_next = first_free_reg;
        have_free_next  = have_free_reg;
        best_idx_next   = best_idx_reg;
        have_match_next = have_match_reg;
        best_dist_next  = best_dist_reg;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        victim_next     = victim_reg;
        if (take)
        begin
            if (entry.last)
            begin
                scan_pos_next   = '0;
                first_free_next = '0;
                have_free_next  = 1'b0;
                best_idx_next   = '0;
                have_match_next = 1'b0;
                best_dist_next  = '0;
                out_valid_next  = 1'b1;
                if (has_focus && upd_have_match)
                begin
                    found_next  = 1'b1;
                    victim_next = to_victim(upd_best_idx);
                end
                else if (upd_have_free)
                begin
                    found_next  = 1'b1;
                    victim_next = to_victim(upd_first_free);
                end
                else
                begin
                    found_next  = 1'b0;
                    victim_next = '0;
                end
            end
            else
            begin
                scan_pos_next   = in_range ? scan_pos_reg + POS_W'(1) : scan_pos_reg;
                first_free_next = upd_first_free;
                have_free_next  = upd_have_free;
                best_idx_next   = upd_best_idx;
                have_match_next = upd_have_match;
                best_dist_next  = upd_best_dist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg   <= '0;
            first_free_reg <= '0;
            have_free_reg  <= 1'b0;
            best_idx_reg   <= '0;
            have_match_reg <= 1'b0;
            best_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_pos_reg   <= scan_pos_next;
            first_free_reg <= first_free_next;
            have_free_reg  <= have_free_next;
            best_idx_reg   <= best_idx_next;
            have_match_reg <= have_match_next;
            best_dist_reg  <= best_dist_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        victim_reg <= victim_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign victim_index = victim_reg;

endmodule

>>> rtl/core/focal_buffer_victim_select_core.sv
// Buffer victim selector. Software streams the buffer entries in scan order, one
// transfer per entry, and marks the final entry with last_entry; that entry yields
// one result (found, victim_index) and restarts the scan at position 0. Without a
// focus the victim is the first entry not in use; with has_focus set it is the free
// entry owned by either focus tag whose start_id is farthest from focus_id, earlier
// entry on a tie, falling back to the first free entry. Entries past MAX_ENTRIES
// are ignored. One entry is taken every cycle unless in_stall holds the input: an
// input register holds the tag match and distance, and the running best-candidate
// compare then updates the scan state; out_valid is registered and rises once the
// last entry has been taken from the input register by that compare.
// in_stall rises only when a scan end meets a result that is still not taken.
// The user writes configuration with cfg_we while no scan is in flight; not enforced.
module focal_buffer_victim_select_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fbvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbvs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               in_use,
    input  logic [fbvs_pkg::TAG_W-1:0]         owner_tag,
    input  logic [fbvs_pkg::ID_W-1:0]          start_id,
    input  logic                               last_entry,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [fbvs_pkg::VICTIM_W-1:0]      victim_index
);
    import fbvs_pkg::*;

    logic             has_focus_reg;
    logic [ID_W-1:0]  focus_id_reg;
    logic [TAG_W-1:0] table_tag_reg;
    logic [TAG_W-1:0] graphic_tag_reg;
    focus_t           focus;
    logic             advance;
    logic             entry_valid;
    entry_t           entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_focus_reg   <= 1'b0;
            focus_id_reg    <= '0;
            table_tag_reg   <= '0;
            graphic_tag_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HAS_FOCUS:     has_focus_reg   <= cfg_data[0];
                CFG_FOCUS_ID:      focus_id_reg    <= cfg_data[ID_W-1:0];
                CFG_FOCUS_TABLE:   table_tag_reg   <= cfg_data[TAG_W-1:0];
                CFG_FOCUS_GRAPHIC: graphic_tag_reg <= cfg_data[TAG_W-1:0];
                default:           has_focus_reg   <= has_focus_reg;
            endcase
        end
    end

    assign focus.focus_id    = focus_id_reg;
    assign focus.table_tag   = table_tag_reg;
    assign focus.graphic_tag = graphic_tag_reg;

    fbvs_entry_stage u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_use      (in_use),
        .owner_tag   (owner_tag),
        .start_id    (start_id),
        .last_entry  (last_entry),
        .focus       (focus),
        .advance     (advance),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    fbvs_tracker u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry        (entry),
        .has_focus    (has_focus_reg),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .victim_index (victim_index)
    );

    // a scan end that moves on always shows a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry.last && advance |=> out_valid)
        else $error("scan end did not produce a result");

    // the input side only waits behind a scan end blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> entry_valid && entry.last && out_valid && out_stall)
        else $error("input stalled without a blocked scan end");

    // no victim reported when nothing was found
    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> victim_index == '0)
        else $error("victim index set on empty result");

endmodule
